>>> sv/assert_macros.svh
// assertion helpers for the transform composer top level
// no dependencies; included by transform_matrix_compose.sv to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock edge outside reset
`define TMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("tmc assertion failed");
// property checked in the cycle after its trigger
`define TMC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("tmc assertion failed");
`endif

>>> sv/tmc_pkg.sv
// types, constants and tables for the transform matrix composer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tmc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH = 2;
	localparam int CORDIC_STEPS = 28;

	localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

	// angle constants in Q32
	localparam logic [35:0] TWO_PI_Q32 = 36'h6487ED511;
	localparam logic [35:0] PI_Q32 = 36'h3243F6A88;
	localparam logic [35:0] HALF_PI_Q32 = 36'h1921FB544;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef enum logic [2:0] {
		ACT_IDENTITY = 3'd0,
		ACT_ROTX = 3'd1,
		ACT_ROTY = 3'd2,
		ACT_ROTZ = 3'd3,
		ACT_TRANSLATE = 3'd4,
		ACT_SCALE = 3'd5,
		ACT_ORTHO = 3'd6,
		ACT_PERSP = 3'd7
	} action_e;

	typedef struct packed {
		logic [2:0] action;
		logic signed [31:0] angle;
		logic signed [31:0] arg_x;
		logic signed [31:0] arg_y;
		logic signed [31:0] arg_z;
		logic signed [31:0] view_width;
		logic signed [31:0] view_height;
		logic signed [31:0] near_plane;
		logic signed [31:0] far_plane;
	} cmd_in_t;

	typedef struct packed {
		logic [3:0] element_index;
		logic signed [31:0] element_value;
		logic divide_error;
		logic last_element;
	} res_out_t;

	// queued request with its class
	typedef struct packed {
		cmd_in_t args;
		logic use_trig;
		logic use_div;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_TRIG,
		BK_DIVGO,
		BK_DIV,
		BK_MUL,
		BK_EMIT
	} back_state_e;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_RED,
		SC_FOLD,
		SC_ITER,
		SC_DONE
	} sc_state_e;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_e;

	// arctangent of 2^-i in Q30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] a;
		case (i)
			5'd0: a = 34'sd843314857;
			5'd1: a = 34'sd497837829;
			5'd2: a = 34'sd263043837;
			5'd3: a = 34'sd133525159;
			5'd4: a = 34'sd67021687;
			5'd5: a = 34'sd33543516;
			5'd6: a = 34'sd16775851;
			5'd7: a = 34'sd8388437;
			5'd8: a = 34'sd4194283;
			5'd9: a = 34'sd2097149;
			default: a = 34'sd1 <<< (5'd30 - i);
		endcase
		return a;
	endfunction

endpackage

>>> sv/tmc_front.sv
// front end: takes requests, classifies them and queues them for the back end
// depends on tmc_pkg
`timescale 1ns / 1ps
module tmc_front (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input tmc_pkg::cmd_in_t cmd,
	output logic q_valid,
	input logic q_pop,
	output tmc_pkg::cmd_t q_head
);
	import tmc_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	cmd_t fifo_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;
	cmd_t entry;
	logic push;

	// classify by the unit the request needs
	always_comb begin
		entry.args = cmd;
		entry.use_trig = cmd.action inside {ACT_ROTX, ACT_ROTY, ACT_ROTZ};
		entry.use_div = cmd.action inside {ACT_ORTHO, ACT_PERSP};
	end

	assign cmd_ready = (count_q != (PW + 1)'(QDEPTH));
	assign push = cmd_valid && cmd_ready;
	assign q_valid = (count_q != '0);
	assign q_head = fifo_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !(q_pop && q_valid)) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop && q_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

>>> sv/tmc_sincos.sv
// sine and cosine unit: angle reduction by shifted subtraction, then iterative cordic
// depends on tmc_pkg
`timescale 1ns / 1ps
module tmc_sincos #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] angle,
	output logic done,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);
	import tmc_pkg::*;

	localparam int RW = 64 - FRAC_BITS;
	localparam int RED_STEPS = 30 - FRAC_BITS;
	localparam int KW = $clog2(RED_STEPS);
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic signed [36:0] PI_S = $signed({1'b0, PI_Q32});
	localparam logic signed [36:0] TWO_PI_S = $signed({1'b0, TWO_PI_Q32});
	localparam logic signed [36:0] HALF_PI_S = $signed({1'b0, HALF_PI_Q32});

	sc_state_e state_q, state_d;
	logic [RW-1:0] mag_q;
	logic neg_q;
	logic [KW-1:0] k_q;
	logic [IW-1:0] i_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic neg_cos_q;

	logic signed [RW-1:0] a_wide;
	logic [RW-1:0] a_mag;
	logic [RW-1:0] sub_val;
	logic signed [36:0] r0, r1, r2;
	logic fold_neg;
	logic signed [33:0] dx, dy, at;
	logic signed [34:0] cos_pre;

	function automatic logic signed [31:0] q30_to_q(input logic signed [34:0] v);
		logic signed [35:0] t;
		t = (36'(v) + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (t > 36'sd2147483647) begin
			return INT32_MAX;
		end else if (t < -36'sd2147483648) begin
			return INT32_MIN;
		end
		return t[31:0];
	endfunction

	// widened angle and its magnitude
	always_comb begin
		a_wide = RW'(angle) <<< (32 - FRAC_BITS);
		a_mag = a_wide[RW-1] ? RW'(-a_wide) : RW'(a_wide);
		sub_val = RW'(TWO_PI_Q32) << k_q;
	end

	// fold the reduced angle into the right half plane
	always_comb begin
		r0 = neg_q ? -$signed({1'b0, mag_q[35:0]}) : $signed({1'b0, mag_q[35:0]});
		if (r0 > PI_S) begin
			r1 = r0 - TWO_PI_S;
		end else if (r0 < -PI_S) begin
			r1 = r0 + TWO_PI_S;
		end else begin
			r1 = r0;
		end
		fold_neg = 1'b0;
		if (r1 > HALF_PI_S) begin
			r2 = PI_S - r1;
			fold_neg = 1'b1;
		end else if (r1 < -HALF_PI_S) begin
			r2 = -PI_S - r1;
			fold_neg = 1'b1;
		end else begin
			r2 = r1;
		end
	end

	// one cordic step
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = atan_q30(i_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: if (start) state_d = SC_RED;
			SC_RED: if (k_q == '0) state_d = SC_FOLD;
			SC_FOLD: state_d = SC_ITER;
			SC_ITER: if (i_q == IW'(CORDIC_STEPS - 1)) state_d = SC_DONE;
			SC_DONE: state_d = SC_IDLE;
			default: state_d = SC_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == SC_DONE);
		cos_pre = neg_cos_q ? -35'(x_q) : 35'(x_q);
		sin_val = q30_to_q(35'(y_q));
		cos_val = q30_to_q(cos_pre);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				mag_q <= a_mag;
				neg_q <= a_wide[RW-1];
				k_q <= KW'(RED_STEPS - 1);
			end
			SC_RED: begin
				if (mag_q >= sub_val) mag_q <= mag_q - sub_val;
				k_q <= k_q - 1'b1;
			end
			SC_FOLD: begin
				z_q <= 34'(r2 >>> 2);
				x_q <= CORDIC_GAIN_Q30;
				y_q <= '0;
				neg_cos_q <= fold_neg;
				i_q <= '0;
			end
			SC_ITER: begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/tmc_div.sv
// signed restoring divider, one quotient bit a cycle, saturated to 32 bits
// depends on tmc_pkg
`timescale 1ns / 1ps
module tmc_div #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32+FRAC_BITS:0] num,
	input logic signed [32:0] den,
	output logic done,
	output logic signed [31:0] quo,
	output logic zero
);
	import tmc_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int CW = $clog2(NUM_W);

	dv_state_e state_q, state_d;
	logic [NUM_W-1:0] sh_q;
	logic [32:0] dmag_q;
	logic [32:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, num_neg_q, zero_q;

	logic [33:0] trial;
	logic ge;

	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign ge = (trial >= {1'b0, dmag_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: if (start) state_d = (den == '0) ? DV_DONE : DV_RUN;
			DV_RUN: if (cnt_q == '0) state_d = DV_DONE;
			DV_DONE: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	// sign and saturation of the quotient
	always_comb begin
		done = (state_q == DV_DONE);
		zero = zero_q;
		if (zero_q) begin
			quo = num_neg_q ? INT32_MIN : INT32_MAX;
		end else if (!neg_q) begin
			quo = (sh_q > NUM_W'(32'h7fffffff)) ? INT32_MAX : $signed(sh_q[31:0]);
		end else begin
			quo = (sh_q > NUM_W'(33'h080000000)) ? INT32_MIN : -$signed(sh_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					sh_q <= num[NUM_W] ? NUM_W'(-num) : NUM_W'(num);
					dmag_q <= den[32] ? 33'(-den) : 33'(den);
					rem_q <= '0;
					cnt_q <= CW'(NUM_W - 1);
					neg_q <= num[NUM_W] ^ den[32];
					num_neg_q <= num[NUM_W];
					zero_q <= (den == '0);
				end
			end
			DV_RUN: begin
				rem_q <= ge ? 33'(trial - {1'b0, dmag_q}) : 33'(trial);
				sh_q <= {sh_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/tmc_back.sv
// back end: builds the elementary matrix, multiplies it in, emits the 16 elements
// depends on tmc_pkg, tmc_sincos and tmc_div
`timescale 1ns / 1ps
module tmc_back #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input tmc_pkg::cmd_t q_head,
	output logic q_pop,
	output logic elem_valid,
	input logic elem_ready,
	output tmc_pkg::res_out_t elem
);
	import tmc_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

	// division order for the projections
	localparam logic [2:0] DS_W = 3'd0;
	localparam logic [2:0] DS_H = 3'd1;
	localparam logic [2:0] DS_DEPTH = 3'd2;
	localparam logic [2:0] DS_NEAR = 3'd3;
	localparam logic [2:0] DS_F = 3'd4;

	back_state_e state_q, state_d;
	cmd_t cmd_q;
	logic signed [31:0] t_q [16];
	logic signed [31:0] m_q [16];
	logic signed [31:0] row_q [3];
	logic [3:0] elem_q;
	logic [2:0] cnt_q;
	logic [2:0] div_sel_q;
	logic err_q;
	logic signed [63:0] prod_s1;
	logic signed [65:0] acc_q;
	res_out_t out_q;
	logic out_valid_q;

	logic emit_ok;
	logic [1:0] row_idx, col_idx, k_idx;
	logic signed [31:0] m_rd, t_rd;
	logic signed [66:0] rnd;
	logic signed [31:0] elem_val;
	logic sc_start, sc_done;
	logic signed [31:0] sc_sin, sc_cos, sc_nsin;
	logic dv_start, dv_done, dv_zero;
	logic signed [31:0] dv_quo;
	logic signed [NUM_W:0] dv_num;
	logic signed [32:0] dv_den;
	logic signed [32:0] depth;
	logic [3:0] div_tidx;
	logic [2:0] div_last;

	// starting value of one entry of the elementary matrix
	function automatic logic signed [31:0] t_seed(input int idx, input cmd_in_t a);
		logic signed [31:0] v;
		v = (idx == 0 || idx == 5 || idx == 10 || idx == 15) ? Q_ONE : '0;
		if (a.action == ACT_TRANSLATE) begin
			if (idx == 12) v = a.arg_x;
			if (idx == 13) v = a.arg_y;
			if (idx == 14) v = a.arg_z;
		end else if (a.action == ACT_SCALE) begin
			if (idx == 0) v = a.arg_x;
			if (idx == 5) v = a.arg_y;
			if (idx == 10) v = a.arg_z;
		end
		return v;
	endfunction

	tmc_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
		.clk(clk),
		.arst_n(arst_n),
		.start(sc_start),
		.angle(q_head.args.angle),
		.done(sc_done),
		.sin_val(sc_sin),
		.cos_val(sc_cos)
	);

	tmc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.num(dv_num),
		.den(dv_den),
		.done(dv_done),
		.quo(dv_quo),
		.zero(dv_zero)
	);

	assign sc_nsin = (sc_sin == INT32_MIN) ? INT32_MAX : -sc_sin;

	// divider operands and destination
	always_comb begin
		depth = 33'(cmd_q.args.far_plane) - 33'(cmd_q.args.near_plane);
		div_last = (cmd_q.args.action == ACT_PERSP) ? DS_F : DS_NEAR;
		case (div_sel_q)
			DS_W: begin
				dv_num = (NUM_W + 1)'(2) <<< (2 * FRAC_BITS);
				dv_den = 33'(cmd_q.args.view_width);
				div_tidx = 4'd0;
			end
			DS_H: begin
				dv_num = (NUM_W + 1)'(2) <<< (2 * FRAC_BITS);
				dv_den = 33'(cmd_q.args.view_height);
				div_tidx = 4'd5;
			end
			DS_DEPTH: begin
				dv_num = (NUM_W + 1)'(1) <<< (2 * FRAC_BITS);
				dv_den = depth;
				div_tidx = 4'd10;
			end
			DS_NEAR: begin
				dv_num = (-(NUM_W + 1)'(cmd_q.args.near_plane)) <<< FRAC_BITS;
				dv_den = depth;
				div_tidx = 4'd14;
			end
			default: begin
				dv_num = (NUM_W + 1)'(1) <<< (2 * FRAC_BITS);
				dv_den = 33'(cmd_q.args.far_plane);
				div_tidx = 4'd11;
			end
		endcase
	end

	// operand selection and rounding of the dot product
	always_comb begin
		row_idx = elem_q[3:2];
		col_idx = elem_q[1:0];
		k_idx = cnt_q[1:0];
		m_rd = m_q[{row_idx, k_idx}];
		t_rd = t_q[{k_idx, col_idx}];
		rnd = (67'(acc_q) + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (rnd > 67'sd2147483647) begin
			elem_val = INT32_MAX;
		end else if (rnd < -67'sd2147483648) begin
			elem_val = INT32_MIN;
		end else begin
			elem_val = rnd[31:0];
		end
		emit_ok = !out_valid_q || elem_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (q_head.use_trig) state_d = BK_TRIG;
					else if (q_head.use_div) state_d = BK_DIVGO;
					else state_d = BK_MUL;
				end
			end
			BK_TRIG: if (sc_done) state_d = BK_MUL;
			BK_DIVGO: state_d = BK_DIV;
			BK_DIV: if (dv_done) state_d = (div_sel_q == div_last) ? BK_MUL : BK_DIVGO;
			BK_MUL: if (cnt_q == 3'd4) state_d = BK_EMIT;
			BK_EMIT: if (emit_ok) state_d = (elem_q == 4'd15) ? BK_IDLE : BK_MUL;
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop = (state_q == BK_IDLE) && q_valid;
		sc_start = q_pop && q_head.use_trig;
		dv_start = (state_q == BK_DIVGO);
		elem_valid = out_valid_q;
		elem = out_q;
	end

	// control state and the current matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			elem_q <= '0;
			cnt_q <= '0;
			div_sel_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				m_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? Q_ONE : '0;
			end
		end else begin
			state_q <= state_d;
			// output register: loaded on emit, emptied on handshake
			if (state_q == BK_EMIT && emit_ok) out_valid_q <= 1'b1;
			else if (elem_ready) out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					elem_q <= '0;
					cnt_q <= '0;
					div_sel_q <= DS_W;
				end
				BK_DIV: begin
					if (dv_done && div_sel_q != div_last) div_sel_q <= div_sel_q + 1'b1;
				end
				BK_MUL: cnt_q <= cnt_q + 1'b1;
				BK_EMIT: begin
					if (emit_ok) begin
						cnt_q <= '0;
						elem_q <= elem_q + 1'b1;
						// row complete: write it back
						if (col_idx == 2'd3) begin
							m_q[{row_idx, 2'd0}] <= row_q[0];
							m_q[{row_idx, 2'd1}] <= row_q[1];
							m_q[{row_idx, 2'd2}] <= row_q[2];
							m_q[{row_idx, 2'd3}] <= elem_val;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// elementary matrix, accumulator and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					cmd_q <= q_head;
					err_q <= 1'b0;
					for (int i = 0; i < 16; i++) t_q[i] <= t_seed(i, q_head.args);
				end
			end
			BK_TRIG: begin
				if (sc_done) begin
					case (cmd_q.args.action)
						ACT_ROTX: begin
							t_q[5] <= sc_cos;
							t_q[6] <= sc_nsin;
							t_q[9] <= sc_sin;
							t_q[10] <= sc_cos;
						end
						ACT_ROTY: begin
							t_q[0] <= sc_cos;
							t_q[2] <= sc_sin;
							t_q[8] <= sc_nsin;
							t_q[10] <= sc_cos;
						end
						default: begin
							t_q[0] <= sc_cos;
							t_q[1] <= sc_nsin;
							t_q[4] <= sc_sin;
							t_q[5] <= sc_cos;
						end
					endcase
				end
			end
			BK_DIV: begin
				if (dv_done) begin
					t_q[div_tidx] <= dv_quo;
					err_q <= err_q | dv_zero;
					if (div_sel_q == DS_F) t_q[15] <= '0;
				end
			end
			BK_MUL: begin
				if (cnt_q != 3'd4) prod_s1 <= m_rd * t_rd;
				if (cnt_q == 3'd1) acc_q <= 66'(prod_s1);
				else if (cnt_q != 3'd0) acc_q <= acc_q + 66'(prod_s1);
			end
			BK_EMIT: begin
				if (emit_ok) begin
					out_q.element_index <= elem_q;
					out_q.element_value <= elem_val;
					out_q.divide_error <= err_q;
					out_q.last_element <= (elem_q == 4'd15);
					if (col_idx != 2'd3) row_q[col_idx] <= elem_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/transform_matrix_compose.sv
// transform matrix composer top level: request queue front end and compute back end
// depends on tmc_pkg, tmc_front, tmc_back and assert_macros.svh
// sequence: identity, translate and scale go straight to the multiply; rotations first run
// 30-FRAC_BITS reduction steps and the cordic; projections first run 4 or 5 divisions;
// the queue takes new requests while the back end works through one request at a time
// reset: current matrix returns to identity, queue and output are emptied
`timescale 1ns / 1ps
`include "assert_macros.svh"
module transform_matrix_compose #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input tmc_pkg::cmd_in_t cmd,
	output logic elem_valid,
	input logic elem_ready,
	output tmc_pkg::res_out_t elem
);
	import tmc_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_head;

	tmc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_head(q_head)
	);

	tmc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.elem(elem)
	);

	// the closing flag marks element fifteen only
	`TMC_ASSERT(a_last_idx, clk, arst_n, !(elem_valid && elem.last_element) || elem.element_index == 4'd15)
	// elements of a run come out in row-major order
	`TMC_ASSERT_NEXT(a_order, clk, arst_n, elem_valid && elem_ready && !elem.last_element, !elem_valid || elem.element_index == $past(elem.element_index) + 4'd1)
	// the error flag is the same across one run
	`TMC_ASSERT_NEXT(a_err_run, clk, arst_n, elem_valid && elem_ready && !elem.last_element, !elem_valid || elem.divide_error == $past(elem.divide_error))

endmodule

>>> verif/tb_transform_matrix_compose.sv
// testbench for transform_matrix_compose: random and directed matrix commands
// checked element by element against a built-in fixed-point predictor; depends on tmc_pkg
`timescale 1ns / 1ps
module tb_transform_matrix_compose;
	import tmc_pkg::*;

	localparam int FB = 16;
	localparam int N_RANDOM = 100;
	localparam int CYCLE_LIMIT = 1000000;
	localparam longint TWO_PI = 64'h6487ED511;
	localparam longint PI = 64'h3243F6A88;
	localparam longint HALF_PI = 64'h1921FB544;
	localparam longint GAIN = 652032874;
	localparam int Q1 = 1 << FB;

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_ready;
	cmd_in_t cmd = '0;
	logic elem_valid;
	logic elem_ready = 0;
	res_out_t elem;

	cmd_in_t pending_cmds[$];
	res_out_t expected_elems[$];
	int xform[16];
	int errors = 0;
	int cycles = 0;
	logic cmd_taken = 0;
	int cmd_gap = 0;
	int ready_stall = 0;
	logic run_started = 0;

	transform_matrix_compose dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.elem_valid(elem_valid), .elem_ready(elem_ready), .elem(elem)
	);

	always #5 clk = ~clk;

	function automatic int sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint atan_step(input int i);
		longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		return (i < 10) ? tab[i] : (64'sd1 <<< (30 - i));
	endfunction

	// angle reduction, fold and cordic, rounded back to the q format
	function automatic void sin_cos(input longint ang, output int sn, output int cs);
		longint r, x, y, z, dx, dy, a;
		bit flip;
		r = (ang * (64'sd1 <<< (32 - FB))) % TWO_PI;
		flip = 0;
		x = GAIN;
		y = 0;
		if (r > PI)
			r -= TWO_PI;
		if (r < -PI)
			r += TWO_PI;
		if (r > HALF_PI) begin
			r = PI - r;
			flip = 1;
		end else if (r < -HALF_PI) begin
			r = -PI - r;
			flip = 1;
		end
		z = r >>> 2;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			a = atan_step(i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= a;
			end else begin
				x += dx;
				y -= dy;
				z += a;
			end
		end
		if (flip)
			x = -x;
		sn = sat32((y + (64'sd1 <<< (29 - FB))) >>> (30 - FB));
		cs = sat32((x + (64'sd1 <<< (29 - FB))) >>> (30 - FB));
	endfunction

	function automatic int quotient(input longint num, input longint den, inout bit err);
		if (den == 0) begin
			err = 1;
			return (num >= 0) ? 32'h7fffffff : 32'h80000000;
		end
		return sat32(num / den);
	endfunction

	// exact 4-term dot product, rounded and saturated
	function automatic int mac_row_col(input int t[16], input int row, input int col);
		logic signed [69:0] acc;
		longint p;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			p = longint'(xform[row * 4 + k]) * longint'(t[k * 4 + col]);
			acc = acc + p;
		end
		if ((acc >>> 32) >= (70'sd1 <<< 30))
			return 32'h7fffffff;
		if ((acc >>> 32) < -(70'sd1 <<< 30))
			return 32'h80000000;
		acc = (acc + (70'sd1 <<< (FB - 1))) >>> FB;
		if (acc > 70'sd2147483647)
			return 32'h7fffffff;
		if (acc < -70'sd2147483648)
			return 32'h80000000;
		return int'(acc);
	endfunction

	// build the elementary matrix, compose and queue the 16 expected elements
	task automatic compose_matrix(input cmd_in_t c);
		int t[16], prod[16], sn, cs;
		bit err;
		longint depth;
		res_out_t r;
		err = 0;
		for (int i = 0; i < 16; i++)
			t[i] = (i % 5 == 0) ? Q1 : 0;
		case (action_e'(c.action))
			ACT_ROTX: begin
				sin_cos(c.angle, sn, cs);
				t[5] = cs; t[6] = sat32(-longint'(sn)); t[9] = sn; t[10] = cs;
			end
			ACT_ROTY: begin
				sin_cos(c.angle, sn, cs);
				t[0] = cs; t[2] = sn; t[8] = sat32(-longint'(sn)); t[10] = cs;
			end
			ACT_ROTZ: begin
				sin_cos(c.angle, sn, cs);
				t[0] = cs; t[1] = sat32(-longint'(sn)); t[4] = sn; t[5] = cs;
			end
			ACT_TRANSLATE: begin
				t[12] = c.arg_x; t[13] = c.arg_y; t[14] = c.arg_z;
			end
			ACT_SCALE: begin
				t[0] = c.arg_x; t[5] = c.arg_y; t[10] = c.arg_z;
			end
			ACT_ORTHO, ACT_PERSP: begin
				depth = longint'(c.far_plane) - longint'(c.near_plane);
				t[0] = quotient(64'sd2 <<< (2 * FB), c.view_width, err);
				t[5] = quotient(64'sd2 <<< (2 * FB), c.view_height, err);
				t[10] = quotient(64'sd1 <<< (2 * FB), depth, err);
				t[14] = quotient(-longint'(c.near_plane) * (64'sd1 <<< FB), depth, err);
				if (action_e'(c.action) == ACT_PERSP) begin
					t[11] = quotient(64'sd1 <<< (2 * FB), c.far_plane, err);
					t[15] = 0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 16; i++)
			prod[i] = mac_row_col(t, i / 4, i % 4);
		for (int i = 0; i < 16; i++) begin
			xform[i] = prod[i];
			r.element_index = 4'(i);
			r.element_value = prod[i];
			r.divide_error = err;
			r.last_element = (i == 15);
			expected_elems.push_back(r);
		end
	endtask

	// mostly modest q values, sometimes the full range
	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'(0);
			default: return 32'($signed($urandom_range(0, 8 * Q1)) - 4 * Q1);
		endcase
	endfunction

	function automatic cmd_in_t make_cmd(input action_e a, input int ang, input int x,
		input int y, input int z, input int w, input int h, input int n, input int f);
		cmd_in_t c;
		c.action = a; c.angle = ang; c.arg_x = x; c.arg_y = y; c.arg_z = z;
		c.view_width = w; c.view_height = h; c.near_plane = n; c.far_plane = f;
		return c;
	endfunction

	// accepted requests feed the predictor, accepted elements are checked
	always @(posedge clk) begin
		res_out_t exp_e;
		cycles <= cycles + 1;
		cmd_taken <= cmd_valid && cmd_ready;
		if (arst_n && elem_valid && elem_ready) begin
			if (expected_elems.size() == 0) begin
				$error("unexpected element index %0d value %0d", elem.element_index,
					elem.element_value);
				errors++;
			end else begin
				exp_e = expected_elems.pop_front();
				if (elem.element_index !== exp_e.element_index) begin
					$error("element_index expected %0d actual %0d", exp_e.element_index,
						elem.element_index);
					errors++;
				end
				if (elem.element_value !== exp_e.element_value) begin
					$error("element_value expected %0d actual %0d", exp_e.element_value,
						elem.element_value);
					errors++;
				end
				if (elem.divide_error !== exp_e.divide_error) begin
					$error("divide_error expected %0b actual %0b", exp_e.divide_error,
						elem.divide_error);
					errors++;
				end
				if (elem.last_element !== exp_e.last_element) begin
					$error("last_element expected %0b actual %0b", exp_e.last_element,
						elem.last_element);
					errors++;
				end
			end
		end
		if (arst_n && cmd_valid && cmd_ready)
			compose_matrix(cmd);
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// request driver with random idle bursts, none near the end
	always @(negedge clk) begin
		if (run_started && (cmd_taken || !cmd_valid)) begin
			if (cmd_gap > 0) begin
				cmd_gap <= cmd_gap - 1;
				cmd_valid <= 0;
			end else if (pending_cmds.size() > 0) begin
				if (pending_cmds.size() > 20 && $urandom_range(0, 3) == 0) begin
					cmd_gap <= $urandom_range(0, 14);
					cmd_valid <= 0;
				end else begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1;
				end
			end else begin
				cmd_valid <= 0;
			end
		end
	end

	// element sink with random stall bursts
	always @(negedge clk) begin
		if (run_started) begin
			if (ready_stall > 0) begin
				ready_stall <= ready_stall - 1;
				elem_ready <= 0;
			end else if (pending_cmds.size() > 20 && $urandom_range(0, 15) == 0) begin
				ready_stall <= $urandom_range(0, 14);
				elem_ready <= 0;
			end else begin
				elem_ready <= 1;
			end
		end
	end

	initial begin
		cmd_in_t c;
		for (int i = 0; i < 16; i++)
			xform[i] = (i % 5 == 0) ? Q1 : 0;
		// directed: every action, angle folds, field extremes, zero divisors
		pending_cmds.push_back(make_cmd(ACT_IDENTITY, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTX, 102944, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTY, 205887, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTZ, -205887, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTX, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTY, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ROTZ, -150000, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_TRANSLATE, 0, 3 * Q1, -2 * Q1, Q1 / 2,
			0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_SCALE, 0, 2 * Q1, -Q1, Q1 / 4, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ORTHO, 0, 0, 0, 0, 4 * Q1, 3 * Q1, Q1, 10 * Q1));
		pending_cmds.push_back(make_cmd(ACT_PERSP, 0, 0, 0, 0, 2 * Q1, 2 * Q1, Q1, 5 * Q1));
		pending_cmds.push_back(make_cmd(ACT_ORTHO, 0, 0, 0, 0, 0, 0, Q1, Q1));
		pending_cmds.push_back(make_cmd(ACT_PERSP, 0, 0, 0, 0, Q1, Q1, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ORTHO, 0, 0, 0, 0, -Q1, Q1, -Q1, -Q1));
		pending_cmds.push_back(make_cmd(ACT_ORTHO, 0, 0, 0, 0, 1, -1, 32'h80000000,
			32'h7fffffff));
		pending_cmds.push_back(make_cmd(ACT_PERSP, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000));
		pending_cmds.push_back(make_cmd(ACT_TRANSLATE, 0, 32'h7fffffff, 32'h80000000,
			32'hffffffff, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_SCALE, 0, 32'h7fffffff, 32'h80000000, 0,
			0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_IDENTITY, 32'hffffffff, -1, -1, -1, -1, -1,
			-1, -1));
		pending_cmds.push_back(make_cmd(ACT_SCALE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_ORTHO, 0, 0, 0, 0, 2 * Q1, 2 * Q1, -Q1, Q1));
		pending_cmds.push_back(make_cmd(ACT_ROTZ, 51472, 0, 0, 0, 0, 0, 0, 0));
		// random commands
		for (int i = 0; i < N_RANDOM; i++) begin
			c.action = 3'($urandom_range(0, 7));
			c.angle = ($urandom_range(0, 3) == 0) ? 32'($urandom)
				: 32'($signed($urandom_range(0, 16 * Q1)) - 8 * Q1);
			c.arg_x = rand_q();
			c.arg_y = rand_q();
			c.arg_z = rand_q();
			c.view_width = rand_q();
			c.view_height = rand_q();
			c.near_plane = rand_q();
			c.far_plane = ($urandom_range(0, 7) == 0) ? c.near_plane : rand_q();
			pending_cmds.push_back(c);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		run_started = 1;
		wait (pending_cmds.size() == 0 && !cmd_valid);
		wait (expected_elems.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_elems.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
